// File: rtl/missing_tooth_wheel_decoder_core_macros.svh
`ifndef MISSING_TOOTH_WHEEL_DECODER_CORE_MACROS_SVH
`define MISSING_TOOTH_WHEEL_DECODER_CORE_MACROS_SVH

// property checked outside reset
`define MTWD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// property checked at every edge, reset included
`define MTWD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// File: rtl/mtwd_pkg.sv
package mtwd_pkg;

   localparam int unsigned TEETH_PRESENT_DEF = 35;
   localparam int unsigned TIME_W            = 32;
   localparam int unsigned TOOTH_INDEX_W     = 6;
   localparam int unsigned EXT_W             = TIME_W + 4;

   localparam logic [TIME_W-1:0] MAX_INTERVAL_RST = 32'd50000000;

   localparam int unsigned K_SHORT   = 7;
   localparam int unsigned K_LIKE    = 17;
   localparam int unsigned K_GAP     = 27;
   localparam int unsigned RATIO_DEN = 10;

   localparam logic PULSE_CRANK = 1'b0;
   localparam logic PULSE_CAM   = 1'b1;

   typedef struct packed {
      logic is_short;
      logic is_like;
      logic is_gap;
   } win_type;

endpackage

// File: rtl/missing_tooth_wheel_decoder_core.sv
// Missing-tooth crank wheel decoder. Each transaction is a crank tooth or cam pulse with its
// timer stamp; each yields exactly one result with sync state, tooth number, half-cycle,
// tooth event and sync-loss flags, and the revolution period at tooth 1. The accept edge
// reads the previous and current ring slots from the timestamp and interval memories; the
// commit edge checks the interval window and writes the slot back, and it waits while a
// stalled result still sits in the output register. A new transaction is accepted in the
// cycle after write-back, while the earlier result may still wait in the output register,
// so no new transaction is taken before the earlier one is written back. Reset clears the
// per-slot valid bits at once; no clearing pass runs. The user must write the max_interval
// register only while no transaction is in flight; the block itself does not enforce it.
module missing_tooth_wheel_decoder_core #(
   parameter int unsigned TEETH_PRESENT = mtwd_pkg::TEETH_PRESENT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [mtwd_pkg::TIME_W-1:0]          req_pulse_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_in_sync,
   output logic [mtwd_pkg::TOOTH_INDEX_W-1:0]   rsp_tooth_index,
   output logic                                 rsp_second_half,
   output logic                                 rsp_tooth_event,
   output logic                                 rsp_sync_lost,
   output logic                                 rsp_period_valid,
   output logic [mtwd_pkg::TIME_W-1:0]          rsp_revolution_period,
   output logic [mtwd_pkg::TIME_W-1:0]          rsp_revolution_count,
   input  logic                                 csr_wr_en,
   input  logic [mtwd_pkg::TIME_W-1:0]          csr_wr_data
);
   import mtwd_pkg::*;

   localparam int unsigned PTR_W  = $clog2(TEETH_PRESENT);
   localparam int unsigned TCNT_W = $clog2(TEETH_PRESENT + 1);
   localparam int unsigned TPOS_W = (TCNT_W > TOOTH_INDEX_W) ? TCNT_W : TOOTH_INDEX_W;
   localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(TEETH_PRESENT - 1);
   localparam logic [TPOS_W-1:0] LAST_TOOTH = TPOS_W'(TEETH_PRESENT);
   localparam logic [TPOS_W-1:0] TOOTH_ONE  = TPOS_W'(1);
   localparam logic [TPOS_W-1:0] TOOTH_TWO  = TPOS_W'(2);

   logic [TIME_W-1:0] time_mem [TEETH_PRESENT];
   logic [TIME_W-1:0] intv_mem [TEETH_PRESENT];
   logic [TEETH_PRESENT-1:0] time_vld_ff, time_vld_in;
   logic [TEETH_PRESENT-1:0] intv_vld_ff, intv_vld_in;

   logic [TIME_W-1:0] max_interval_ff, max_interval_in;
   logic              synced_ff, synced_in;
   logic [1:0]        pcount_ff, pcount_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [TPOS_W-1:0] tpos_ff, tpos_in;
   logic              half_ff, half_in;
   logic              cam_ff, cam_in;
   logic [TIME_W-1:0] revcnt_ff, revcnt_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_type_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic [TIME_W-1:0] tprev_rd_ff, tcur_rd_ff, iprev_rd_ff;
   logic              tprev_vld_ff, tcur_vld_ff, iprev_vld_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_in_sync_ff;
   logic [TOOTH_INDEX_W-1:0] rsp_tooth_index_ff;
   logic              rsp_second_half_ff;
   logic              rsp_tooth_event_ff;
   logic              rsp_sync_lost_ff;
   logic              rsp_period_valid_ff;
   logic [TIME_W-1:0] rsp_period_ff;
   logic [TIME_W-1:0] rsp_count_ff;

   logic              accept;
   logic              commit;
   logic [PTR_W-1:0]  prev_slot;
   logic [PTR_W-1:0]  next_slot;
   logic [TIME_W-1:0] tprev;
   logic [TIME_W-1:0] tcur;
   logic [TIME_W-1:0] iprev;
   logic [TIME_W-1:0] delta;
   logic              delta_pos;
   logic [1:0]        pc_inc;
   win_type           win;

   logic              time_we;
   logic              intv_we;
   logic [TIME_W-1:0] intv_wdata;
   logic              evt;
   logic              lost;
   logic              pvalid;
   logic [TIME_W-1:0] period;

   assign req_stall = s1_valid_ff;
   assign accept    = req_valid && !s1_valid_ff;
   assign commit    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign prev_slot = (ptr_ff == '0) ? LAST_SLOT : ptr_ff - PTR_W'(1);
   assign next_slot = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + PTR_W'(1);

   assign tprev     = tprev_vld_ff ? tprev_rd_ff : '0;
   assign tcur      = tcur_vld_ff  ? tcur_rd_ff  : '0;
   assign iprev     = iprev_vld_ff ? iprev_rd_ff : '0;
   assign delta     = s1_time_ff - tprev;
   assign delta_pos = (delta != '0) && !delta[TIME_W-1];
   assign pc_inc    = (pcount_ff == 2'd3) ? 2'd3 : pcount_ff + 2'd1;

   mtwd_window u_window (
      .interval      (delta),
      .prev_interval (iprev),
      .win           (win)
   );

   always_comb begin
      logic              ok;
      logic [TPOS_W-1:0] tooth;

      ok          = 1'b0;
      tooth       = tpos_ff;
      synced_in   = synced_ff;
      pcount_in   = pcount_ff;
      ptr_in      = ptr_ff;
      tpos_in     = tpos_ff;
      half_in     = half_ff;
      cam_in      = cam_ff;
      revcnt_in   = revcnt_ff;
      time_we     = 1'b0;
      intv_we     = 1'b0;
      intv_wdata  = delta;
      evt         = 1'b0;
      lost        = 1'b0;
      pvalid      = 1'b0;
      period      = '0;

      if (s1_type_ff == PULSE_CAM) begin
         cam_in = 1'b1;
      end else begin
         pcount_in = pc_inc;
         time_we   = 1'b1;
         if (!synced_ff) begin
            if (pc_inc == 2'd2) begin
               intv_we = 1'b1;
               if (!delta_pos) begin
                  intv_wdata = '0;
                  pcount_in  = 2'd1;
               end
            end else if (pc_inc == 2'd3 && delta_pos) begin
               intv_we = 1'b1;
               if (win.is_short) begin
                  tpos_in   = TOOTH_TWO;
                  half_in   = !cam_ff;
                  synced_in = 1'b1;
                  cam_in    = 1'b0;
               end else if (!win.is_like && win.is_gap) begin
                  tpos_in   = TOOTH_ONE;
                  half_in   = !cam_ff;
                  synced_in = 1'b1;
                  cam_in    = 1'b0;
               end
            end
            ptr_in = next_slot;
         end else begin
            if (!delta_pos || delta > max_interval_ff) begin
               ok = 1'b0;
            end else if (tpos_ff == TOOTH_ONE) begin
               ok = win.is_short;
            end else if (tpos_ff == LAST_TOOTH) begin
               ok = win.is_gap;
            end else begin
               ok = win.is_like;
            end

            if (!ok) begin
               lost = 1'b1;
            end else begin
               intv_we = 1'b1;
               tooth   = tpos_ff + TPOS_W'(1);
               if (tpos_ff == LAST_TOOTH) begin
                  tooth     = TOOTH_ONE;
                  lost      = (half_ff != cam_ff);
                  half_in   = !cam_ff;
                  cam_in    = 1'b0;
                  revcnt_in = revcnt_ff + TIME_W'(1);
               end
               tpos_in = tooth;
               ptr_in  = next_slot;
               if (!lost) begin
                  evt = 1'b1;
                  if (tpos_ff == LAST_TOOTH) begin
                     pvalid = 1'b1;
                     period = s1_time_ff - tcur;
                  end
               end
            end
            if (lost) begin
               synced_in = 1'b0;
               pcount_in = 2'd0;
            end
         end
      end
   end

   always_comb begin
      max_interval_in = csr_wr_en ? csr_wr_data : max_interval_ff;

      time_vld_in = time_vld_ff;
      intv_vld_in = intv_vld_ff;
      if (commit && time_we) begin
         time_vld_in[ptr_ff] = 1'b1;
      end
      if (commit && intv_we) begin
         intv_vld_in[ptr_ff] = 1'b1;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_interval_ff <= MAX_INTERVAL_RST;
         synced_ff       <= 1'b0;
         pcount_ff       <= 2'd0;
         ptr_ff          <= '0;
         tpos_ff         <= '0;
         half_ff         <= 1'b0;
         cam_ff          <= 1'b0;
         revcnt_ff       <= '0;
         time_vld_ff     <= '0;
         intv_vld_ff     <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         max_interval_ff <= max_interval_in;
         time_vld_ff     <= time_vld_in;
         intv_vld_ff     <= intv_vld_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (commit) begin
            synced_ff <= synced_in;
            pcount_ff <= pcount_in;
            ptr_ff    <= ptr_in;
            tpos_ff   <= tpos_in;
            half_ff   <= half_in;
            cam_ff    <= cam_in;
            revcnt_ff <= revcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit && time_we) begin
         time_mem[ptr_ff] <= s1_time_ff;
      end
      if (commit && intv_we) begin
         intv_mem[ptr_ff] <= intv_wdata;
      end
      if (accept) begin
         s1_type_ff   <= req_type;
         s1_time_ff   <= req_pulse_time;
         tprev_rd_ff  <= time_mem[prev_slot];
         tcur_rd_ff   <= time_mem[ptr_ff];
         iprev_rd_ff  <= intv_mem[prev_slot];
         tprev_vld_ff <= time_vld_ff[prev_slot];
         tcur_vld_ff  <= time_vld_ff[ptr_ff];
         iprev_vld_ff <= intv_vld_ff[prev_slot];
      end
      if (commit) begin
         rsp_in_sync_ff      <= synced_in;
         rsp_tooth_index_ff  <= tpos_in[TOOTH_INDEX_W-1:0];
         rsp_second_half_ff  <= half_in;
         rsp_tooth_event_ff  <= evt;
         rsp_sync_lost_ff    <= lost;
         rsp_period_valid_ff <= pvalid;
         rsp_period_ff       <= period;
         rsp_count_ff        <= revcnt_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_in_sync           = rsp_in_sync_ff;
   assign rsp_tooth_index       = rsp_tooth_index_ff;
   assign rsp_second_half       = rsp_second_half_ff;
   assign rsp_tooth_event       = rsp_tooth_event_ff;
   assign rsp_sync_lost         = rsp_sync_lost_ff;
   assign rsp_period_valid      = rsp_period_valid_ff;
   assign rsp_revolution_period = rsp_period_ff;
   assign rsp_revolution_count  = rsp_count_ff;

endmodule

// File: rtl/mtwd_window.sv
module mtwd_window (
   input  logic [mtwd_pkg::TIME_W-1:0] interval,
   input  logic [mtwd_pkg::TIME_W-1:0] prev_interval,
   output mtwd_pkg::win_type           win
);
   import mtwd_pkg::*;

   logic [EXT_W-1:0]  d_x10;
   logic [EXT_W-1:0]  d1_x10;
   logic [TIME_W-1:0] q_short;
   logic [TIME_W-1:0] q_like;
   logic [TIME_W-1:0] q_gap;

   // limits wrap in 32 bits; compare ten times the interval against them
   assign q_short = prev_interval * TIME_W'(K_SHORT);
   assign q_like  = prev_interval * TIME_W'(K_LIKE);
   assign q_gap   = prev_interval * TIME_W'(K_GAP);

   assign d_x10  = {{(EXT_W-TIME_W){1'b0}}, interval} * EXT_W'(RATIO_DEN);
   assign d1_x10 = d_x10 + EXT_W'(RATIO_DEN);

   assign win.is_short = d1_x10 <= {{(EXT_W-TIME_W){1'b0}}, q_short};
   assign win.is_like  = (d_x10 <= {{(EXT_W-TIME_W){1'b0}}, q_like}) &&
                         (d_x10 >  {{(EXT_W-TIME_W){1'b0}}, q_short});
   assign win.is_gap   = (d_x10 >  {{(EXT_W-TIME_W){1'b0}}, q_like}) &&
                         (d_x10 <= {{(EXT_W-TIME_W){1'b0}}, q_gap});

endmodule

// File: rtl/mtwd_checker.sv
`include "missing_tooth_wheel_decoder_core_macros.svh"

module mtwd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_in_sync,
   input logic [mtwd_pkg::TOOTH_INDEX_W-1:0]   rsp_tooth_index,
   input logic                                 rsp_tooth_event,
   input logic                                 rsp_sync_lost,
   input logic                                 rsp_period_valid,
   input logic [mtwd_pkg::TIME_W-1:0]          rsp_revolution_count
);
   import mtwd_pkg::*;

   `MTWD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)
   `MTWD_ASSERT(a_period_at_tooth1, clock, reset, rsp_valid && rsp_period_valid |-> rsp_tooth_event && rsp_in_sync && rsp_tooth_index == TOOTH_INDEX_W'(1))
   `MTWD_ASSERT(a_lost_no_event, clock, reset, rsp_valid && rsp_sync_lost |-> !rsp_in_sync && !rsp_tooth_event)
   `MTWD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_revolution_count))

endmodule

bind missing_tooth_wheel_decoder_core mtwd_checker u_mtwd_checker (.*);
